// ===== hdl/ehne_pkg.sv =====
// ----------------------------------------------------------------------------
// ehne_pkg
// Shared types and constants of the escaped Hamming nibble encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ehne_pkg;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_MARK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_ESCAPE = 2'd0,
    REG_CANCEL = 2'd1,
    REG_END    = 2'd2
  } reg_idx_t;

  localparam logic [7:0] EscapeReset = 8'd27;
  localparam logic [7:0] CancelReset = 8'd24;
  localparam logic [7:0] EndReset    = 8'd4;

  typedef struct packed {
    logic [7:0] escape_char;
    logic [7:0] cancel_char;
    logic [7:0] end_char;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [3:0][7:0] data;
  } blk_t;

endpackage

`default_nettype wire

// ===== hdl/ehne_regs.sv =====
// ----------------------------------------------------------------------------
// ehne_regs
// APB register file holding the escape, cancel and end characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ehne_regs
  import ehne_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.escape_char <= EscapeReset;
      regs.cancel_char <= CancelReset;
      regs.end_char    <= EndReset;
    end else if (wr) begin
      case (idx)
        REG_ESCAPE: regs.escape_char <= pwdata[7:0];
        REG_CANCEL: regs.cancel_char <= pwdata[7:0];
        REG_END:    regs.end_char    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ESCAPE: prdata = {24'd0, regs.escape_char};
      REG_CANCEL: prdata = {24'd0, regs.cancel_char};
      REG_END:    prdata = {24'd0, regs.end_char};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ehne_pack.sv =====
// ----------------------------------------------------------------------------
// ehne_pack
// Escapes data bytes, collects them four at a time and holds a finished
// block until the serializer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ehne_pack
  import ehne_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // byte_value
  input  wire logic [1:0] s_tuser,   // op
  input  wire logic       take,
  output blk_t            blk
);

  logic [3:0][7:0] byte_buffer;
  logic [3:0][7:0] byte_buffer_next;
  logic [1:0]      fill_count;
  logic [1:0]      fill_count_next;
  logic            pend_valid;
  logic [3:0][7:0] pend_data;

  logic [3:0][7:0] stage;
  logic [7:0]      first;
  logic            push;
  logic            push_two;
  logic            flush;
  logic            complete;
  logic            carry;
  logic            is_esc;
  logic [2:0]      fill_sum;
  logic            accept;

  assign s_tready = !pend_valid || take;
  assign accept   = s_tvalid && s_tready;
  assign blk      = '{valid: pend_valid, data: pend_data};

  assign is_esc = (s_tdata == cfg.escape_char) || (s_tdata == cfg.cancel_char) ||
                  (s_tdata == cfg.end_char);

  always_comb begin
    stage    = byte_buffer;
    first    = s_tdata;
    push     = 1'b0;
    push_two = 1'b0;
    flush    = 1'b0;
    complete = 1'b0;
    case (op_t'(s_tuser))
      OP_DATA: begin
        push = 1'b1;
        if (is_esc) begin
          push_two = 1'b1;
          first    = cfg.escape_char;
        end
      end
      OP_MARK:  push = 1'b1;
      OP_FLUSH: flush = (fill_count != 2'd0);
      default: ;
    endcase

    fill_sum = {1'b0, fill_count} + (push_two ? 3'd2 : 3'd1);
    carry    = push_two && (fill_count == 2'd3);

    if (push) begin
      stage[fill_count] = first;
      if (push_two && fill_count != 2'd3) begin
        stage[fill_count + 2'd1] = s_tdata;
      end
      complete = fill_sum[2];
    end
    if (flush) begin
      for (int i = 0; i < 4; i++) begin
        if (2'(i) >= fill_count) begin
          stage[i] = s_tdata;
        end
      end
      complete = 1'b1;
    end

    byte_buffer_next = stage;
    if (carry) begin
      byte_buffer_next[0] = s_tdata;
    end

    if (complete) begin
      fill_count_next = carry ? 2'd1 : 2'd0;
    end else if (push) begin
      fill_count_next = fill_sum[1:0];
    end else begin
      fill_count_next = fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= 2'd0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
      end
      if (accept && complete) begin
        pend_valid <= 1'b1;
      end else if (take) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_buffer <= byte_buffer_next;
    end
    if (accept && complete) begin
      pend_data <= stage;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ehne_ser.sv =====
// ----------------------------------------------------------------------------
// ehne_ser
// Forms the eight Hamming(8,4) code bytes of a block and sends them as
// sixteen nibbles, low nibble first.
// ----------------------------------------------------------------------------
`default_nettype none

module ehne_ser
  import ehne_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire blk_t       blk,
  output logic            take,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // symbol, zero
  output logic            m_tlast
);

  function automatic logic [7:0][7:0] encode(input logic [3:0][7:0] d);
    logic [7:0][7:0] c;
    c[0] = d[0] ^ d[1] ^ d[3];
    c[1] = d[0] ^ d[2] ^ d[3];
    c[2] = d[0];
    c[3] = d[1] ^ d[2] ^ d[3];
    c[4] = d[1];
    c[5] = d[2];
    c[6] = d[3];
    c[7] = d[0] ^ d[1] ^ d[2];
    return c;
  endfunction

  logic [15:0][3:0] code;
  logic [3:0]       cnt;
  logic             ser_valid;
  logic             at_end;
  logic             beat;

  assign at_end   = (cnt == 4'hF);
  assign beat     = ser_valid && m_tready;
  assign take     = blk.valid && (!ser_valid || (beat && at_end));
  assign m_tvalid = ser_valid;
  assign m_tdata  = {4'd0, code[cnt]};
  assign m_tlast  = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      cnt       <= 4'd0;
    end else if (take) begin
      ser_valid <= 1'b1;
      cnt       <= 4'd0;
    end else if (beat) begin
      cnt <= cnt + 4'd1;
      if (at_end) begin
        ser_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code <= encode(blk.data);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/escaped_hamming_nibble_encoder.sv =====
// ----------------------------------------------------------------------------
// escaped_hamming_nibble_encoder
// Escapes bytes, groups them by four and sends extended Hamming(8,4) code
// bytes as nibbles.
// ----------------------------------------------------------------------------
// A byte is taken whenever no finished block is waiting or the waiting block
// is being taken; every fourth buffered byte (or a flush) completes a block of
// sixteen symbols, which the serializer sends at one symbol per cycle while
// m_tready is high, so the output serializer sets the sustained rate. One
// finished block may wait while the previous one is still being sent.
`default_nettype none

module escaped_hamming_nibble_encoder
  import ehne_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // byte_value
  input  wire logic [1:0]  s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // symbol[3:0], zero[7:4]
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  blk_t blk;
  logic take;

  ehne_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ehne_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (take),
    .blk      (blk)
  );

  ehne_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .blk      (blk),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/ehne_checker.sv =====
// ----------------------------------------------------------------------------
// ehne_checker
// Port-level checks of the escaped Hamming nibble encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module ehne_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'd0)
    else $error("symbol padding bits not zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("apb access stalled");

endmodule

bind escaped_hamming_nibble_encoder ehne_checker u_chk (.*);

`default_nettype wire
